[hw/rtl/slcan_pkg.sv]
// Shared types, character codes and hex decode for the ASCII CAN line parser.
`default_nettype none

package slcan_pkg;

   localparam logic [7:0] CHAR_CR  = 8'h0D;
   localparam logic [7:0] CHAR_STD = 8'h74;   // 't'
   localparam logic [7:0] CHAR_EXT = 8'h54;   // 'T'

   localparam int unsigned STD_ID_DIGITS = 3;
   localparam int unsigned EXT_ID_DIGITS = 8;

   typedef enum logic [1:0] {
      KIND_NONE = 2'd0,
      KIND_STD  = 2'd1,
      KIND_EXT  = 2'd2
   } kind_type;

   // Everything that describes the line in progress, bar its position.
   typedef struct packed {
      kind_type    kind;
      logic [31:0] id_acc;
      logic        id_invalid;
      logic [3:0]  length;
      logic [63:0] data;
      logic [3:0]  held;
      logic [3:0]  pend_nibble;
      logic        nibble_wait;
   } line_type;

   typedef struct packed {
      logic        is_extended;
      logic [31:0] frame_id;
      logic [3:0]  declared_length;
      logic [3:0]  byte_count;
      logic [63:0] payload;
      logic        length_truncated;
   } frame_type;

   // Bit 4 set means the character is not a hex digit.
   function automatic logic [4:0] hex_digit(input logic [7:0] c);
      logic [4:0] r;
      case (c) inside
         [8'h30:8'h39]: r = {1'b0, 4'(c - 8'h30)};
         [8'h41:8'h46]: r = {1'b0, 4'(c - 8'h41 + 8'd10)};
         [8'h61:8'h66]: r = {1'b0, 4'(c - 8'h61 + 8'd10)};
         default:       r = 5'h10;
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

[hw/rtl/slcan_if.sv]
// Valid/ready channel interfaces for received characters and decoded frames.
`default_nettype none

interface slcan_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

interface slcan_rsp_if;
   logic        valid;
   logic        ready;
   logic        is_extended;
   logic [31:0] frame_id;
   logic [3:0]  declared_length;
   logic [3:0]  byte_count;
   logic [63:0] payload;
   logic        length_truncated;

   modport source (output valid, output is_extended, output frame_id,
                   output declared_length, output byte_count, output payload,
                   output length_truncated, input ready);
   modport sink (input valid, input is_extended, input frame_id,
                 input declared_length, input byte_count, input payload,
                 input length_truncated, output ready);
endinterface

`default_nettype wire

[hw/rtl/slcan_ascii_frame_parser.sv]
// Top level: ASCII CAN line parser, one character per cycle to decoded frames.
//
//   channel   dir  contents                                   accepted when
//   req_chan  in   rx_byte, one received character            valid && ready
//   rsp_chan  out  one decoded frame per 't'/'T' line at CR   valid && ready
//
// One character is taken every cycle; decode and line state update are
// combinational, and a frame appears in the result register on the cycle after
// its carriage return. Reset clears the line state and the valid flag, not the
// frame data. Requests stall only while a finished frame waits and rsp_chan is
// not ready; the result register lets the next character in as it drains.
`default_nettype none

module slcan_ascii_frame_parser
   import slcan_pkg::*;
#(
   parameter int unsigned MAX_DATA_BYTES  = 8,
   parameter int unsigned MAX_LINE_LENGTH = 4096
) (
   input wire logic    clock,
   input wire logic    reset,
   slcan_req_if.sink   req_chan,
   slcan_rsp_if.source rsp_chan
);

   localparam int unsigned PW = $clog2(MAX_LINE_LENGTH + 1);

   logic [PW-1:0] pos_ff, pos_in;
   line_type      line_ff, line_in;
   logic          rsp_valid_ff, rsp_valid_in;
   frame_type     frame_ff, frame_in;
   logic          emit;
   logic          req_take;

   assign req_chan.ready = ~rsp_valid_ff | rsp_chan.ready;
   assign req_take       = req_chan.valid & req_chan.ready;

   slcan_char_step #(
      .MAX_DATA_BYTES  (MAX_DATA_BYTES),
      .MAX_LINE_LENGTH (MAX_LINE_LENGTH)
   ) u_step (
      .char_in   (req_chan.rx_byte),
      .pos       (pos_ff),
      .line      (line_ff),
      .pos_next  (pos_in),
      .line_next (line_in),
      .emit      (emit),
      .frame     (frame_in)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff & ~rsp_chan.ready;
      if (req_take && emit) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         line_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (req_take) begin
            pos_ff  <= pos_in;
            line_ff <= line_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take && emit) frame_ff <= frame_in;
   end

   assign rsp_chan.valid            = rsp_valid_ff;
   assign rsp_chan.is_extended      = frame_ff.is_extended;
   assign rsp_chan.frame_id         = frame_ff.frame_id;
   assign rsp_chan.declared_length  = frame_ff.declared_length;
   assign rsp_chan.byte_count       = frame_ff.byte_count;
   assign rsp_chan.payload          = frame_ff.payload;
   assign rsp_chan.length_truncated = frame_ff.length_truncated;

   a_cr_clears_line: assert property (@(posedge clock) disable iff (reset)
      req_take && req_chan.rx_byte == CHAR_CR |=> pos_ff == '0 && line_ff.kind == KIND_NONE)
      else $error("line state not cleared after carriage return");

   a_held_capped: assert property (@(posedge clock) disable iff (reset)
      line_ff.held <= 4'(MAX_DATA_BYTES))
      else $error("payload byte count exceeds capacity");

   a_pos_bounded: assert property (@(posedge clock) disable iff (reset)
      {1'b0, pos_ff} <= (PW+1)'(MAX_LINE_LENGTH))
      else $error("line position beyond maximum line length");

   a_frame_from_cr: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(req_take && req_chan.rx_byte == CHAR_CR))
      else $error("frame raised without a carriage return");

endmodule

`default_nettype wire

[hw/rtl/slcan_char_step.sv]
// Per-character line state update and frame assembly.
`default_nettype none

module slcan_char_step
   import slcan_pkg::*;
#(
   parameter int unsigned MAX_DATA_BYTES  = 8,
   parameter int unsigned MAX_LINE_LENGTH = 4096,
   localparam int unsigned PW = $clog2(MAX_LINE_LENGTH + 1)
) (
   input  wire logic [7:0]    char_in,
   input  wire logic [PW-1:0] pos,
   input  wire line_type      line,
   output logic [PW-1:0]      pos_next,
   output line_type           line_next,
   output logic               emit,
   output frame_type          frame
);

   localparam int unsigned CW = (PW > 6) ? PW : 6;

   logic [4:0]    hex;
   logic          is_hex;
   logic [5:0]    id_end;
   logic [5:0]    win_end;
   logic [CW-1:0] pos_w;
   logic [PW:0]   pos_inc;
   logic [7:0]    data_byte;

   assign hex       = hex_digit(char_in);
   assign is_hex    = ~hex[4];
   assign id_end    = (line.kind == KIND_EXT) ? 6'(EXT_ID_DIGITS) : 6'(STD_ID_DIGITS);
   assign win_end   = id_end + 6'd1 + {1'b0, line.length, 1'b0};
   assign pos_w     = CW'(pos);
   assign pos_inc   = {1'b0, pos} + {{PW{1'b0}}, 1'b1};
   assign data_byte = {line.pend_nibble, hex[3:0]};

   always_comb begin
      line_next = line;
      pos_next  = pos;
      emit      = 1'b0;
      if (char_in == CHAR_CR) begin
         emit      = (line.kind != KIND_NONE);
         line_next = '0;
         pos_next  = '0;
      end else begin
         if (pos == '0) begin
            if (char_in == CHAR_STD) line_next.kind = KIND_STD;
            else if (char_in == CHAR_EXT) line_next.kind = KIND_EXT;
            else line_next.kind = KIND_NONE;
         end else if (line.kind != KIND_NONE) begin
            if (pos_w <= CW'(id_end)) begin
               if (is_hex) line_next.id_acc = {line.id_acc[27:0], hex[3:0]};
               else line_next.id_invalid = 1'b1;
            end else if (pos_w == CW'(id_end + 6'd1)) begin
               line_next.length = is_hex ? hex[3:0] : 4'd0;
            end else if (pos_w <= CW'(win_end) && is_hex) begin
               if (line.nibble_wait) begin
                  // beyond capacity the byte is decoded but dropped
                  if (line.held < 4'(MAX_DATA_BYTES)) begin
                     for (int i = 0; i < MAX_DATA_BYTES; i++) begin
                        if (line.held[2:0] == 3'(i)) line_next.data[8*i +: 8] = data_byte;
                     end
                     line_next.held = line.held + 4'd1;
                  end
                  line_next.nibble_wait = 1'b0;
               end else begin
                  line_next.pend_nibble = hex[3:0];
                  line_next.nibble_wait = 1'b1;
               end
            end
         end
         // overlong line without terminator: start afresh
         if (pos_inc > (PW+1)'(MAX_LINE_LENGTH)) begin
            line_next = '0;
            pos_next  = '0;
         end else begin
            pos_next = pos_inc[PW-1:0];
         end
      end
   end

   always_comb begin
      frame.is_extended      = (line.kind == KIND_EXT);
      frame.frame_id         = line.id_invalid ? 32'd0 : line.id_acc;
      frame.declared_length  = line.length;
      frame.byte_count       = line.held;
      frame.payload          = line.data;
      frame.length_truncated = (line.length > 4'(MAX_DATA_BYTES));
   end

endmodule

`default_nettype wire
